/* src/tkz_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Expression tokenizer package
// Shared types and constants for the character lexer, the token queue and
// the result emitter.
// ---------------------------------------------------------------------------
package tkz_pkg;

	// Default configuration of the top level.
	localparam int POS_BITS_DEF   = 16;
	localparam int FIFO_DEPTH_DEF = 4;

	// A single character can produce at most three tokens.
	localparam int MAX_RES = 3;

	// Token classes as they leave the block.
	typedef enum logic [3:0] {
		K_NUMBER,
		K_IMAG,
		K_VAR,
		K_EQUAL,
		K_MAT_OPEN,
		K_MAT_CLOSE,
		K_PAREN_OPEN,
		K_PAREN_CLOSE,
		K_COMMA,
		K_SEMI,
		K_QUERY,
		K_OPER,
		K_END
	} kind_t;

	// Operator sub-codes; only meaningful for K_OPER.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_MATMUL,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW
	} op_t;

	// Lexer modes: what kind of token is pending.
	typedef enum logic [2:0] {
		M_IDLE,
		M_INT,
		M_DOT,
		M_FRAC,
		M_IDENT,
		M_STAR
	} mode_t;

	// Input word: one character.
	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} in_word_t;

	// One token as stored between the front and the back.
	typedef struct packed {
		kind_t       token_kind;
		op_t         op_kind;
		logic [15:0] start_pos;
		logic [15:0] token_len;
	} tok_t;

	// Output word.
	typedef struct packed {
		kind_t       token_kind;
		op_t         op_kind;
		logic [15:0] start_pos;
		logic [15:0] token_len;
		logic        run_last;
	} out_word_t;

	typedef logic [1:0] res_cnt_t;

	// All tokens caused by one character, oldest in slot zero.
	typedef struct packed {
		res_cnt_t                cnt;
		tok_t [MAX_RES-1:0]      tok;
	} bundle_t;

	// Write side of the token queue.
	typedef struct packed {
		logic    en;
		bundle_t data;
	} q_wr_t;

	// Read side of the token queue.
	typedef struct packed {
		logic    avail;
		bundle_t data;
	} q_rd_t;

endpackage
`default_nettype wire

/* src/tkz_lex.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer front end
// Takes one character per cycle unless full, advances the lexer state and
// writes every token the character completes into the queue as one bundle.
// ---------------------------------------------------------------------------
module tkz_lex #(
	parameter int POS_BITS = tkz_pkg::POS_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              full,
	input  wire tkz_pkg::in_word_t item,
	output tkz_pkg::q_wr_t         qwr
);
	import tkz_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] LEN_ONE = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] LEN_TWO = POS_BITS'(2);

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LOW_I = 8'h69;
	localparam logic [7:0] CH_UP_I  = 8'h49;

	typedef struct packed {
		logic  hit;
		kind_t kind;
		op_t   op;
	} sym_t;

	// Saturating increment of a position or length.
	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + LEN_ONE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic tok_t mk_tok(input kind_t k, input op_t o,
			input logic [POS_BITS-1:0] s, input logic [POS_BITS-1:0] l);
		tok_t t;
		t.token_kind = k;
		t.op_kind    = o;
		t.start_pos  = 16'(s);
		t.token_len  = 16'(l);
		return t;
	endfunction

	// Single-character symbols.
	function automatic sym_t symbol_of(input logic [7:0] c);
		sym_t s;
		s = '{hit: 1'b1, kind: K_OPER, op: OP_NONE};
		case (c)
			8'h3D: s.kind = K_EQUAL;
			8'h5B: s.kind = K_MAT_OPEN;
			8'h5D: s.kind = K_MAT_CLOSE;
			8'h28: s.kind = K_PAREN_OPEN;
			8'h29: s.kind = K_PAREN_CLOSE;
			8'h2C: s.kind = K_COMMA;
			8'h3B: s.kind = K_SEMI;
			8'h3F: s.kind = K_QUERY;
			8'h2B: s.op   = OP_ADD;
			8'h2D: s.op   = OP_SUB;
			8'h2F: s.op   = OP_DIV;
			8'h25: s.op   = OP_MOD;
			8'h5E: s.op   = OP_POW;
			default: s.hit = 1'b0;
		endcase
		return s;
	endfunction

	// Whether a mode holds a token that a flush would emit.
	function automatic logic has_pend(input mode_t m);
		return m inside {M_INT, M_DOT, M_FRAC, M_IDENT, M_STAR};
	endfunction

	// Token emitted when the pending token is flushed.
	function automatic tok_t flush_tok(input mode_t m, input logic [POS_BITS-1:0] s,
			input logic [POS_BITS-1:0] l, input logic si);
		tok_t t;
		case (m)
			M_IDENT: t = mk_tok(si ? K_IMAG : K_VAR, OP_NONE, s, l);
			M_STAR:  t = mk_tok(K_OPER, OP_MUL, s, LEN_ONE);
			default: t = mk_tok(K_NUMBER, OP_NONE, s, l);
		endcase
		return t;
	endfunction

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [POS_BITS-1:0] len_q, len_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic                si_q, si_d;
	bundle_t             bnd;
	logic                brk;
	logic                take;
	sym_t                sym;

	assign take = push && !full;
	assign sym  = symbol_of(item.ch);

	// Lexer step: next state and the tokens this character completes.
	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		si_d    = si_q;
		bnd     = '0;
		brk     = 1'b0;

		// Continue the pending token, or note that it ends here.
		case (mode_q)
			M_INT: begin
				if (is_digit(item.ch)) begin
					len_d = sat_inc(len_q);
				end else if (item.ch == CH_DOT) begin
					mode_d = M_DOT;
				end else begin
					brk = 1'b1;
				end
			end
			M_DOT: begin
				if (is_digit(item.ch)) begin
					len_d  = sat_inc(sat_inc(len_q));
					mode_d = M_FRAC;
				end else begin
					brk = 1'b1;
				end
			end
			M_FRAC: begin
				if (is_digit(item.ch)) begin
					len_d = sat_inc(len_q);
				end else begin
					brk = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_alpha(item.ch) || is_digit(item.ch) || item.ch == CH_UNDER) begin
					len_d = sat_inc(len_q);
					si_d  = 1'b0;
				end else begin
					brk = 1'b1;
				end
			end
			M_STAR: begin
				if (item.ch == CH_STAR) begin
					bnd.tok[bnd.cnt] = mk_tok(K_OPER, OP_MATMUL, start_q, LEN_TWO);
					bnd.cnt          = bnd.cnt + 2'd1;
					mode_d           = M_IDLE;
				end else begin
					brk = 1'b1;
				end
			end
			default: begin
				brk = 1'b1;
			end
		endcase

		// Flush the old token and lex the character afresh.
		if (brk) begin
			if (has_pend(mode_q)) begin
				bnd.tok[bnd.cnt] = flush_tok(mode_q, start_q, len_q, si_q);
				bnd.cnt          = bnd.cnt + 2'd1;
			end
			mode_d = M_IDLE;
			si_d   = 1'b0;
			if (is_digit(item.ch)) begin
				mode_d  = M_INT;
				start_d = pos_q;
				len_d   = LEN_ONE;
			end else if (is_alpha(item.ch)) begin
				mode_d  = M_IDENT;
				start_d = pos_q;
				len_d   = LEN_ONE;
				si_d    = (item.ch == CH_LOW_I) || (item.ch == CH_UP_I);
			end else if (item.ch == CH_STAR) begin
				mode_d  = M_STAR;
				start_d = pos_q;
				len_d   = LEN_ONE;
			end else if (sym.hit) begin
				bnd.tok[bnd.cnt] = mk_tok(sym.kind, sym.op, pos_q, LEN_ONE);
				bnd.cnt          = bnd.cnt + 2'd1;
			end
		end

		// End of line: flush whatever is pending and close the line.
		if (item.line_end) begin
			if (has_pend(mode_d)) begin
				bnd.tok[bnd.cnt] = flush_tok(mode_d, start_d, len_d, si_d);
				bnd.cnt          = bnd.cnt + 2'd1;
			end
			bnd.tok[bnd.cnt] = mk_tok(K_END, OP_NONE, sat_inc(pos_q), '0);
			bnd.cnt          = bnd.cnt + 2'd1;
			mode_d  = M_IDLE;
			si_d    = 1'b0;
			start_d = '0;
			len_d   = '0;
			pos_d   = '0;
		end else begin
			pos_d = sat_inc(pos_q);
		end
	end

	// Queue write: only characters that complete a token.
	assign qwr.en   = take && (bnd.cnt != 2'd0);
	assign qwr.data = bnd;

	// Lexer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			si_q    <= 1'b0;
		end else if (take) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			si_q    <= si_d;
		end
	end

endmodule
`default_nettype wire

/* src/tkz_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Token bundle queue
// A short first-in first-out store that decouples the lexer from the
// result emitter.
// ---------------------------------------------------------------------------
module tkz_fifo #(
	parameter int FIFO_DEPTH = tkz_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tkz_pkg::q_wr_t qwr,
	output logic                full,
	input  wire logic           rd_en,
	output tkz_pkg::q_rd_t      qrd
);
	import tkz_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	bundle_t        mem_q [FIFO_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_rd;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full      = (cnt_q == CW'(FIFO_DEPTH));
	assign qrd.avail = (cnt_q != '0);
	assign qrd.data  = mem_q[rd_ptr_q];
	assign do_rd     = rd_en && qrd.avail;

	// Storage.
	always_ff @(posedge clk) begin
		if (qwr.en) begin
			mem_q[wr_ptr_q] <= qwr.data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (qwr.en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (qwr.en && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !qwr.en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* src/tkz_emit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer result emitter
// Holds one bundle in an output register and hands its tokens out one word
// per pop, marking the last token of the bundle.
// ---------------------------------------------------------------------------
module tkz_emit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tkz_pkg::q_rd_t qrd,
	output logic                rd_en,
	output logic                empty,
	input  wire logic           pop,
	output tkz_pkg::out_word_t  token
);
	import tkz_pkg::*;

	bundle_t  bnd_q;
	logic     valid_q;
	res_cnt_t idx_q;
	logic     at_last;
	logic     load;
	tok_t     cur;

	assign at_last = (idx_q == bnd_q.cnt - 2'd1);
	assign empty   = !valid_q;

	// A new bundle is taken when the register is free or its last word leaves.
	assign load  = qrd.avail && (!valid_q || (pop && at_last));
	assign rd_en = load;

	// Select the current token of the held bundle.
	always_comb begin
		case (idx_q)
			2'd0:    cur = bnd_q.tok[0];
			2'd1:    cur = bnd_q.tok[1];
			default: cur = bnd_q.tok[2];
		endcase
	end

	assign token.token_kind = cur.token_kind;
	assign token.op_kind    = cur.op_kind;
	assign token.start_pos  = cur.start_pos;
	assign token.token_len  = cur.token_len;
	assign token.run_last   = at_last;

	// Bundle payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= qrd.data;
		end
	end

	// Valid flag and word index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/expression_tokenizer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Expression tokenizer
// Streaming lexer for arithmetic and matrix expressions: characters in,
// token records (kind, operator, start, length) out.
// ---------------------------------------------------------------------------
//  Channel   Handshake        Word
//  item      push / full      in_word_t  (ch, line_end)
//  token     pop / empty      out_word_t (kind, op, start, length, run_last)
//
//  The lexer takes one character every cycle while full is low; its state
//  step is combinational. Each character causes zero to three tokens,
//  which leave one word per pop, so a character with k tokens holds the
//  output for k pops. A queue of FIFO_DEPTH bundles lies between lexer
//  and output, and full rises only when that queue is full. Reset clears
//  lexer state, queue pointers and output valid flag; no clearing pass.
// ---------------------------------------------------------------------------
module expression_tokenizer #(
	parameter int POS_BITS   = tkz_pkg::POS_BITS_DEF,
	parameter int FIFO_DEPTH = tkz_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire tkz_pkg::in_word_t  item,
	output logic                    empty,
	input  wire logic               pop,
	output tkz_pkg::out_word_t      token
);
	import tkz_pkg::*;

	q_wr_t qwr;
	q_rd_t qrd;
	logic  rd_en;

	// Front end: lexer.
	tkz_lex #(
		.POS_BITS(POS_BITS)
	) u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.qwr    (qwr)
	);

	// Queue between front and back.
	tkz_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.full   (full),
		.rd_en  (rd_en),
		.qrd    (qrd)
	);

	// Back end: one token word per pop.
	tkz_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.qrd    (qrd),
		.rd_en  (rd_en),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

endmodule
`default_nettype wire
